/* rtl/core/mrsm_pkg.sv */
// Shared types and constants of the masked rule state mapper.
package mrsm_pkg;
	localparam int STATE_WORDS = 2;
	localparam int MAX_ENTRIES = 32;
	localparam int MAX_RULES   = 4;
	localparam int MAX_CONDS   = 4;

	localparam logic [1:0] MODE_COND  = 2'd0;
	localparam logic [1:0] MODE_RULE  = 2'd1;
	localparam logic [1:0] MODE_ENTRY = 2'd2;
	localparam logic [1:0] MODE_BASE  = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  entry_sel;
		logic [1:0]  rule_sel;
		logic [1:0]  cond_sel;
		logic [2:0]  word_sel;
		logic [31:0] mask_bits;
		logic [31:0] data_bits;
		logic        pass_flag;
		logic [2:0]  item_count;
		logic [1:0]  default_sel;
		logic        final_word;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  out_index;
		logic [31:0] out_word;
		logic        last_out;
	} out_word_t;

	typedef struct packed {
		logic [31:0] mask;
		logic [2:0]  word;
		logic [1:0]  def;
		logic [2:0]  count;
	} entry_t;

	typedef struct packed {
		logic [31:0] value;
		logic        pass;
		logic [2:0]  count;
	} rule_t;

	typedef struct packed {
		logic [31:0] mask;
		logic [31:0] value;
	} cond_t;
endpackage

/* rtl/core/mrsm_stream_if.sv */
// Valid/ready channel interfaces for input and result words.
interface mrsm_in_if;
	logic               valid;
	logic               ready;
	mrsm_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mrsm_out_if;
	logic                valid;
	logic                ready;
	mrsm_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/masked_rule_state_mapper.sv */
// Top level of the masked rule state mapper.
// Usage: words arrive on in_ch (valid/ready). Modes 0..2 load the condition,
// rule and entry tables; mode 3 loads a base state word. A mode 3 word with
// final_word set starts an apply: the block walks entry_count entries (at most 32) and
// returns STATE_WORDS result words on out_ch, the last one with last_out set.
// cfg_we/cfg_data write entry_count; write only while idle.
// Memories clear after reset in a sweep, one row of each memory a cycle (the
// condition memory holds one rule's 4x2 condition words per row), during which
// in_ch.ready is low. An apply takes each entry through entry read and wait,
// then for each rule checked a rule and condition row read, wait and compare,
// then one more rule step when none matched, and an update; after the last
// entry it sends the result words.
// The entry walk is set by the single read port of each table memory.
// One word is accepted at a time; when the receiver stalls, the result word
// holds in the output register and the block waits.
module masked_rule_state_mapper (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [5:0]         cfg_data,
	mrsm_in_if.sink            in_ch,
	mrsm_out_if.source         out_ch
);
	localparam int CROW = mrsm_pkg::MAX_CONDS * mrsm_pkg::STATE_WORDS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_ERD, S_EWAIT, S_RRD, S_RWAIT, S_CHK, S_UPD, S_EMIT
	} state_t;

	// table memories
	mrsm_pkg::entry_t entry_mem [mrsm_pkg::MAX_ENTRIES];
	mrsm_pkg::rule_t  rule_mem  [mrsm_pkg::MAX_ENTRIES*mrsm_pkg::MAX_RULES];
	mrsm_pkg::cond_t  cond_mem  [mrsm_pkg::MAX_ENTRIES*mrsm_pkg::MAX_RULES][CROW];

	state_t state_q;
	logic [6:0]  clr_q;
	logic [5:0]  entry_count_q;
	logic [31:0] base_q [mrsm_pkg::STATE_WORDS];
	logic [31:0] work_q [mrsm_pkg::STATE_WORDS];
	logic [5:0]  e_q;
	logic [2:0]  r_q;
	logic [2:0]  emit_q;
	logic        found_q;
	mrsm_pkg::entry_t ent_q;
	mrsm_pkg::rule_t  rule_rd_q;
	mrsm_pkg::cond_t  cond_rd_q [CROW];
	mrsm_pkg::rule_t  pick_rule_q;
	logic        out_valid_q;
	mrsm_pkg::out_word_t out_q;

	// memory ports
	logic        ent_we, rule_we, cond_we;
	logic [4:0]  ent_wa;
	logic [6:0]  rule_wa;
	logic [6:0]  cond_wa;
	logic [2:0]  cond_wc;
	logic        cond_wrow;
	mrsm_pkg::entry_t ent_wd;
	mrsm_pkg::rule_t  rule_wd;
	mrsm_pkg::cond_t  cond_wd;
	logic [6:0]  rd_addr;
	mrsm_pkg::entry_t ent_rd_s1;
	mrsm_pkg::rule_t  rule_rd_s1;
	mrsm_pkg::cond_t  cond_rd_s1 [CROW];

	mrsm_pkg::in_word_t iw;
	logic in_acc;
	logic cond_hit;
	logic [2:0] ecnt, rcnt;

	assign iw = in_ch.data;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	// write side: loads, or the clearing sweep
	always_comb begin
		ent_we = 1'b0; rule_we = 1'b0; cond_we = 1'b0; cond_wrow = 1'b0;
		ent_wa = iw.entry_sel;
		rule_wa = {iw.entry_sel, iw.rule_sel};
		cond_wa = {iw.entry_sel, iw.rule_sel};
		cond_wc = {iw.cond_sel, iw.word_sel[0]};
		ent_wd = '{mask: iw.mask_bits, word: iw.word_sel, def: iw.default_sel,
			count: iw.item_count};
		rule_wd = '{value: iw.data_bits, pass: iw.pass_flag, count: iw.item_count};
		cond_wd = '{mask: iw.mask_bits, value: iw.data_bits};
		if (state_q == S_CLEAR) begin
			ent_we = 1'b1; rule_we = 1'b1; cond_wrow = 1'b1;
			ent_wa = clr_q[4:0];
			rule_wa = clr_q;
			cond_wa = clr_q;
			ent_wd = '0; rule_wd = '0; cond_wd = '0;
		end else if (in_acc) begin
			case (iw.mode)
				mrsm_pkg::MODE_COND:  cond_we = (iw.word_sel < 3'(mrsm_pkg::STATE_WORDS));
				mrsm_pkg::MODE_RULE:  rule_we = 1'b1;
				mrsm_pkg::MODE_ENTRY: ent_we = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		rd_addr = {e_q[4:0], r_q[1:0]};
	end

	always_ff @(posedge clk) begin
		if (ent_we) entry_mem[ent_wa] <= ent_wd;
		if (rule_we) rule_mem[rule_wa] <= rule_wd;
		for (int i = 0; i < CROW; i++) begin
			if (cond_wrow || (cond_we && cond_wc == 3'(i))) cond_mem[cond_wa][i] <= cond_wd;
		end
		ent_rd_s1 <= entry_mem[e_q[4:0]];
		rule_rd_s1 <= rule_mem[rd_addr];
		for (int i = 0; i < CROW; i++) cond_rd_s1[i] <= cond_mem[rd_addr][i];
	end

	// any condition of the current rule holds
	always_comb begin
		logic ok;
		cond_hit = 1'b0;
		rcnt = (rule_rd_q.count > 3'(mrsm_pkg::MAX_CONDS)) ?
			3'(mrsm_pkg::MAX_CONDS) : rule_rd_q.count;
		for (int c = 0; c < mrsm_pkg::MAX_CONDS; c++) begin
			ok = (3'(c) < rcnt);
			for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++) begin
				ok = ok && ((base_q[w] & cond_rd_q[c*mrsm_pkg::STATE_WORDS+w].mask) ==
					cond_rd_q[c*mrsm_pkg::STATE_WORDS+w].value);
			end
			cond_hit = cond_hit || ok;
		end
		ecnt = (ent_q.count > 3'(mrsm_pkg::MAX_RULES)) ? 3'(mrsm_pkg::MAX_RULES) : ent_q.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			entry_count_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
			e_q <= '0; r_q <= '0; emit_q <= '0;
			found_q <= 1'b0;
			ent_q <= '0; rule_rd_q <= '0; pick_rule_q <= '0;
			for (int i = 0; i < CROW; i++) cond_rd_q[i] <= '0;
			for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++) begin
				base_q[w] <= '0; work_q[w] <= '0;
			end
		end else begin
			if (cfg_we) entry_count_q <= cfg_data;
			// drop the output word once taken, unless the emit step refills it
			if (out_valid_q && out_ch.ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 7'd1;
					if (clr_q == 7'd127) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc && iw.mode == mrsm_pkg::MODE_BASE) begin
						if (iw.word_sel < 3'(mrsm_pkg::STATE_WORDS))
							base_q[iw.word_sel[0]] <= iw.data_bits;
						if (iw.final_word) begin
							for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++) begin
								work_q[w] <= (iw.word_sel == 3'(w)) ? iw.data_bits : base_q[w];
							end
							e_q <= '0;
							state_q <= S_ERD;
						end
					end
				end
				S_ERD: begin
					// start the current entry, or finish when all entries are done
					if (e_q >= entry_count_q || e_q >= 6'(mrsm_pkg::MAX_ENTRIES)) begin
						emit_q <= '0;
						state_q <= S_EMIT;
					end else begin
						r_q <= '0; found_q <= 1'b0;
						state_q <= S_EWAIT;
					end
				end
				S_EWAIT: begin
					ent_q <= ent_rd_s1;
					state_q <= S_RRD;
				end
				S_RRD: begin
					if (ecnt == 3'd0 || r_q >= ecnt) state_q <= S_UPD;
					else state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					rule_rd_q <= rule_rd_s1;
					for (int i = 0; i < CROW; i++) cond_rd_q[i] <= cond_rd_s1[i];
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!found_q && ent_q.def == r_q[1:0]) pick_rule_q <= rule_rd_q;
					if (cond_hit) begin
						found_q <= 1'b1;
						pick_rule_q <= rule_rd_q;
						state_q <= S_UPD;
					end else begin
						r_q <= r_q + 3'd1;
						state_q <= S_RRD;
					end
				end
				S_UPD: begin
					if (ecnt != 3'd0 && (found_q || {1'b0, ent_q.def} < ecnt) &&
						!pick_rule_q.pass && ent_q.word < 3'(mrsm_pkg::STATE_WORDS)) begin
						work_q[ent_q.word[0]] <= (work_q[ent_q.word[0]] & ~ent_q.mask) |
							pick_rule_q.value;
					end
					e_q <= e_q + 6'd1;
					state_q <= S_ERD;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_q.out_index <= emit_q;
						out_q.out_word <= work_q[emit_q[0]];
						out_q.last_out <= (emit_q == 3'(mrsm_pkg::STATE_WORDS - 1));
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'(mrsm_pkg::STATE_WORDS - 1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sim/masked_rule_state_mapper_tb.sv */
// Self-checking testbench for the masked rule state mapper: table loads, applies, stalls.
module masked_rule_state_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_data = '0;

	mrsm_in_if in_ch ();
	mrsm_out_if out_ch ();

	masked_rule_state_mapper dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	// Model state of the mapper tables, kept at the block's widths.
	logic [31:0]      base_mem [mrsm_pkg::STATE_WORDS];
	mrsm_pkg::entry_t entry_mem [mrsm_pkg::MAX_ENTRIES];
	mrsm_pkg::rule_t  rule_mem [mrsm_pkg::MAX_ENTRIES][mrsm_pkg::MAX_RULES];
	mrsm_pkg::cond_t  cond_mem [mrsm_pkg::MAX_ENTRIES][mrsm_pkg::MAX_RULES]
		[mrsm_pkg::MAX_CONDS][mrsm_pkg::STATE_WORDS];
	logic [5:0]  live_entries;

	mrsm_pkg::in_word_t  pending_words[$];
	mrsm_pkg::out_word_t mapped_words[$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  hold_out = 0;    // long receiver hold-off request
	bit  pause_in = 0;    // sender holds until drained

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic bit cond_hit(int e, int r, int c);
		for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++)
			if ((base_mem[w] & cond_mem[e][r][c][w].mask) != cond_mem[e][r][c][w].value)
				return 0;
		return 1;
	endfunction

	// Fold one accepted word into the model; push result words on an apply.
	task automatic predict_mapping(input mrsm_pkg::in_word_t iw);
		logic [31:0] work [mrsm_pkg::STATE_WORDS];
		mrsm_pkg::out_word_t ow;
		int n, rn, cn, pick;
		case (iw.mode)
			mrsm_pkg::MODE_COND: if (iw.word_sel < mrsm_pkg::STATE_WORDS) begin
				cond_mem[iw.entry_sel][iw.rule_sel][iw.cond_sel][iw.word_sel].mask =
					iw.mask_bits;
				cond_mem[iw.entry_sel][iw.rule_sel][iw.cond_sel][iw.word_sel].value =
					iw.data_bits;
			end
			mrsm_pkg::MODE_RULE: rule_mem[iw.entry_sel][iw.rule_sel] =
				'{value: iw.data_bits, pass: iw.pass_flag, count: iw.item_count};
			mrsm_pkg::MODE_ENTRY: entry_mem[iw.entry_sel] =
				'{mask: iw.mask_bits, word: iw.word_sel, def: iw.default_sel,
				count: iw.item_count};
			default: begin
				if (iw.word_sel < mrsm_pkg::STATE_WORDS) base_mem[iw.word_sel] = iw.data_bits;
				if (iw.final_word) begin
					for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++) work[w] = base_mem[w];
					n = (live_entries > mrsm_pkg::MAX_ENTRIES) ? mrsm_pkg::MAX_ENTRIES
						: live_entries;
					for (int e = 0; e < n; e++) begin
						rn = (entry_mem[e].count > mrsm_pkg::MAX_RULES) ? mrsm_pkg::MAX_RULES
							: entry_mem[e].count;
						if (rn == 0) continue;
						pick = -1;
						for (int r = 0; r < rn && pick < 0; r++) begin
							cn = (rule_mem[e][r].count > mrsm_pkg::MAX_CONDS) ?
								mrsm_pkg::MAX_CONDS : rule_mem[e][r].count;
							for (int c = 0; c < cn; c++)
								if (cond_hit(e, r, c)) pick = r;
						end
						if (pick < 0) begin
							if (entry_mem[e].def >= rn) continue;
							pick = entry_mem[e].def;
						end
						if (rule_mem[e][pick].pass || entry_mem[e].word >= mrsm_pkg::STATE_WORDS)
							continue;
						work[entry_mem[e].word] = (work[entry_mem[e].word] & ~entry_mem[e].mask)
							| rule_mem[e][pick].value;
					end
					for (int w = 0; w < mrsm_pkg::STATE_WORDS; w++) begin
						ow.out_index = w[2:0];
						ow.out_word = work[w];
						ow.last_out = (w == mrsm_pkg::STATE_WORDS - 1);
						mapped_words.push_back(ow);
					end
				end
			end
		endcase
	endtask

	// Driver: offer words from the pending queue with random gaps.
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			in_gap <= $urandom_range(0, 5);
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_mapping(in_ch.data);
				void'(pending_words.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
				// hold the offered word
			end else if (in_gap > 0) begin
				in_ch.valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_words.size() > 0 && !pause_in) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_words[0];
				in_gap <= $urandom_range(0, 5);
			end else
				in_ch.valid <= 1'b0;
		end
	end

	// Monitor: random ready stalls and result checking against the oldest expectation.
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (mapped_words.size() == 0)
					report($sformatf("unexpected word idx %0d", out_ch.data.out_index));
				else begin
					mrsm_pkg::out_word_t exp_w;
					exp_w = mapped_words.pop_front();
					if (out_ch.data.out_index !== exp_w.out_index)
						report($sformatf("index %0d exp %0d", out_ch.data.out_index, exp_w.out_index));
					if (out_ch.data.out_word !== exp_w.out_word)
						report($sformatf("word %h exp %h", out_ch.data.out_word, exp_w.out_word));
					if (out_ch.data.last_out !== exp_w.last_out)
						report($sformatf("last %b exp %b", out_ch.data.last_out, exp_w.last_out));
				end
			end
			if (hold_out) out_ch.ready <= 1'b0;
			else if (out_ch.valid && out_ch.ready || out_gap == 0 && !out_ch.ready) begin
				if (out_ch.valid && out_ch.ready) begin
					out_gap <= $urandom_range(0, 5);
					out_ch.ready <= 1'b0;
				end else out_ch.ready <= 1'b1;
			end else if (out_gap > 0) out_gap <= out_gap - 1;
		end
	end

	// Watchdog: count cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic mrsm_pkg::in_word_t rand_word();
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		return bits[$bits(mrsm_pkg::in_word_t)-1:0];
	endfunction

	// Build one table program with random content, some fields out of range, then three applies.
	task automatic queue_program(input int entries);
		mrsm_pkg::in_word_t w;
		for (int e = 0; e < entries; e++) begin
			w = rand_word(); w.mode = mrsm_pkg::MODE_ENTRY; w.entry_sel = e[4:0];
			w.word_sel = ($urandom_range(0, 100) < 90) ? 3'($urandom_range(0, 1))
				: 3'($urandom_range(2, 7));
			w.item_count = ($urandom_range(0, 100) < 85) ? 3'($urandom_range(1, 4))
				: 3'($urandom_range(0, 7));
			pending_words.push_back(w);
			for (int r = 0; r < 4; r++) begin
				w = rand_word(); w.mode = mrsm_pkg::MODE_RULE; w.entry_sel = e[4:0];
				w.rule_sel = r[1:0];
				w.item_count = 3'($urandom_range(0, 5));
				w.pass_flag = ($urandom_range(0, 3) == 0);
				pending_words.push_back(w);
				if ($urandom_range(0, 1)) begin
					w = rand_word(); w.mode = mrsm_pkg::MODE_COND; w.entry_sel = e[4:0];
					w.rule_sel = r[1:0];
					w.cond_sel = 2'($urandom_range(0, 3)); w.word_sel = 3'($urandom_range(0, 2));
					w.mask_bits = $urandom & 32'h0000_00ff;
					w.data_bits = $urandom & w.mask_bits & 32'h0000_0003;
					pending_words.push_back(w);
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			w = rand_word(); w.mode = mrsm_pkg::MODE_BASE; w.word_sel = 3'd0;
			w.final_word = 1'b0;
			w.data_bits = $urandom & 32'hffff_ff03;
			pending_words.push_back(w);
			w = rand_word(); w.mode = mrsm_pkg::MODE_BASE;
			w.word_sel = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(2, 7)) : 3'd1;
			w.final_word = 1'b1; w.data_bits = $urandom & 32'hffff_ff03;
			pending_words.push_back(w);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || mapped_words.size() > 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [5:0] v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_data <= v; live_entries = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		mrsm_pkg::in_word_t w;
		int seen;
		live_entries = 0;
		for (int s = 0; s < mrsm_pkg::STATE_WORDS; s++) base_mem[s] = '0;
		foreach (entry_mem[e]) entry_mem[e] = '0;
		foreach (rule_mem[e, r]) rule_mem[e][r] = '0;
		foreach (cond_mem[e, r, c, s]) cond_mem[e][r][c][s] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: apply on cleared tables, extremes, out-of-range loads, zero entries.
		write_entry_count(6'd63);
		w = '0; w.mode = mrsm_pkg::MODE_BASE; w.data_bits = '1; w.final_word = 1'b1;
		pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_ENTRY; w.entry_sel = 5'd31; w.item_count = 3'd7;
		w.mask_bits = '1; w.word_sel = 3'd1; w.default_sel = 2'd3; pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_RULE; w.entry_sel = 5'd31; w.rule_sel = 2'd3;
		w.item_count = 3'd7; w.data_bits = 32'hdead_beef; pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_COND; w.entry_sel = 5'd31; w.rule_sel = 2'd3;
		w.cond_sel = 2'd3; w.word_sel = 3'd7; w.mask_bits = '1; w.data_bits = '1;
		pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_ENTRY; w.entry_sel = 5'd0; w.item_count = 3'd1;
		w.word_sel = 3'd0; w.default_sel = 2'd2; w.mask_bits = '1; pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_RULE; w.entry_sel = 5'd0; w.rule_sel = 2'd0;
		w.item_count = 3'd0; w.pass_flag = 1'b1; pending_words.push_back(w);
		w = '0; w.mode = mrsm_pkg::MODE_BASE; w.word_sel = 3'd0; w.data_bits = 32'h5555_aaaa;
		pending_words.push_back(w);
		w = '1; w.mode = mrsm_pkg::MODE_BASE; w.word_sel = 3'd6; w.final_word = 1'b1;
		pending_words.push_back(w);
		wait_drained();
		write_entry_count(6'd0);
		w = '1; w.mode = mrsm_pkg::MODE_BASE; w.word_sel = 3'd1; pending_words.push_back(w);
		w.final_word = 1'b1; w.word_sel = 3'd0; pending_words.push_back(w);
		wait_drained();

		// Random programs under several entry counts, small mostly.
		seen = 0;
		while (seen < 380) begin
			write_entry_count(($urandom_range(0, 3) == 0) ? 6'(32 + $urandom_range(0, 31))
				: 6'($urandom_range(1, 8)));
			queue_program($urandom_range(1, 4));
			repeat ($urandom_range(0, 6)) pending_words.push_back(rand_word());
			seen += pending_words.size();
			if (seen > 120 && seen < 200) begin
				// receiver holds off while the sender keeps offering
				hold_out = 1;
				repeat (400) @(posedge clk);
				hold_out = 0;
			end
			wait_drained();
		end
		// Sender pause until every result is in, then one final apply.
		pause_in = 1;
		w = '1; w.mode = mrsm_pkg::MODE_BASE; w.final_word = 1'b1; pending_words.push_back(w);
		wait (mapped_words.size() == 0);
		pause_in = 0;
		wait_drained();

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
